>>> hdl/assert_macros.svh
// Assertion macros used by the checker file of the timekeeper.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define TNTK_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("timekeeper check failed: same-cycle implication");

// Next-cycle implication, switched off while reset is asserted.
`define TNTK_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("timekeeper check failed: next-cycle implication");

// Condition that must hold in the cycle after reset is sampled low.
`define TNTK_ASSERT_RST(lbl, clk, rstn, cons) \
    lbl: assert property (@(posedge clk) !(rstn) |=> (cons)) \
        else $error("timekeeper check failed: state after reset");

`endif

>>> hdl/tntk_pkg.sv
// Types and constants shared by the timekeeper modules.
package tntk_pkg;

    // Field widths.
    localparam int TICK_W   = 64;
    localparam int FREQ_W   = 40;
    localparam int KIND_W   = 2;
    localparam int NS_W     = 64;
    localparam int US_W     = 55;
    localparam int MS_W     = 45;
    localparam int STATUS_W = 2;
    localparam int MULT_W   = 32;
    localparam int SHIFT_W  = 5;

    // Packed output data: time_ns, time_us, time_ms, padded to whole bytes.
    localparam int M_DATA_USED = NS_W + US_W + MS_W;
    localparam int M_DATA_W    = ((M_DATA_USED + 7) / 8) * 8;
    localparam int NS_LSB      = 0;
    localparam int US_LSB      = NS_W;
    localparam int MS_LSB      = NS_W + US_W;

    // Calibration constants.
    localparam int NS_SEC_W = 30;
    localparam logic [NS_SEC_W-1:0] NS_PER_SEC = NS_SEC_W'(1000000000);
    localparam logic [SHIFT_W-1:0]  MAX_SHIFT  = SHIFT_W'(30);
    localparam int CAL_DVD_W = NS_SEC_W + 30;
    localparam logic [FREQ_W-1:0]   FREQ_RESET = FREQ_W'(1000000000);

    // Constant divisors for the microsecond and millisecond fields.
    localparam int CDIV_W = 20;
    localparam logic [CDIV_W-1:0] DIV_US = CDIV_W'(1000);
    localparam logic [CDIV_W-1:0] DIV_MS = CDIV_W'(1000000);
    localparam int CDIV_BITS = 8;

    // Sequencer step counts.
    localparam int CNT_W      = 5;
    localparam int CAL_STEPS  = MULT_W;
    localparam int QDIV_STEPS = NS_W / CDIV_BITS;

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_INIT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_UPDATE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_PARAM = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_INIT  = 2'd2;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_FAULT,
        S_SEARCH,
        S_CAL_DIV,
        S_CAL_COMMIT,
        S_MUL,
        S_ADD,
        S_QDIV,
        S_DONE
    } tntk_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;
        logic search_init;
        logic search_dec;
        logic cal_load;
        logic cal_step;
        logic cal_commit;
        logic mul;
        logic add;
        logic fault;
        logic qdiv_step;
        logic out_load;
    } tntk_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic kind_init;
        logic freq_zero;
        logic calibrated;
        logic search_hit;
        logic out_free;
    } tntk_sts_t;

endpackage

>>> hdl/tick_to_nanosecond_timekeeper_top.sv
// Top level of the tick-to-nanosecond timekeeper.
//
// Usage: each input transfer carries a raw tick count on s_tdata and an item
// kind on s_tuser (init and calibrate, update, read). Each item gives exactly
// one result transfer: time in ns, us and ms packed on m_tdata and a status
// code on m_tuser. The tick frequency register is written through cfg_wr_en
// and cfg_wr_data; write it only while the block is idle, which the block
// itself does not enforce; it is used at the next init. Items are worked on
// one at a time. An update or read passes through decoding, the multiply,
// the shift and add, the constant dividers, which produce eight quotient bits
// per cycle, and the loading of the output register; the next item is
// accepted once the sequencer is back in idle. An init adds the shift search,
// the one-bit-per-cycle calibration divider and a step that stores the new
// scale. A faulty item (zero frequency or not calibrated) goes from decoding
// straight to the constant dividers with a zero time. Reset clears the
// calibration and the stored time, empties the output register and sets the
// frequency to 1 GHz. If the receiver stalls, the result holds in the output
// register and the next item may still be accepted and worked on; it then
// waits for the register to empty.
module tick_to_nanosecond_timekeeper_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [tntk_pkg::TICK_W-1:0]         s_tdata,   // tick_count
    input  logic [tntk_pkg::KIND_W-1:0]         s_tuser,   // kind
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [tntk_pkg::M_DATA_W-1:0]       m_tdata,   // time_ns, time_us, time_ms
    output logic [tntk_pkg::STATUS_W-1:0]       m_tuser,   // status
    input  logic                                cfg_wr_en,
    input  logic [tntk_pkg::FREQ_W-1:0]         cfg_wr_data
);
    import tntk_pkg::*;

    tntk_cmd_t cmd;
    tntk_sts_t sts;

    // Sequencer.
    tntk_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Arithmetic and storage.
    tntk_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

>>> hdl/tntk_cdiv.sv
// Divider by a constant, producing eight quotient bits per step.
module tntk_cdiv (
    input  logic                          aclk,
    input  logic                          load,
    input  logic [tntk_pkg::NS_W-1:0]     dvd_in,
    input  logic                          step,
    input  logic [tntk_pkg::CDIV_W-1:0]   divisor,
    output logic [tntk_pkg::NS_W-1:0]     quot
);
    import tntk_pkg::*;

    logic [CDIV_W-1:0] rem_reg;
    logic [CDIV_W-1:0] rem_next;
    logic [NS_W-1:0]   num_reg;
    logic [NS_W-1:0]   num_next;

    // Restoring division: the dividend shifts out at the top while the
    // quotient bits shift in at the bottom.
    always_comb begin
        logic [CDIV_W:0]   trial;
        logic [CDIV_W-1:0] r;
        logic [NS_W-1:0]   n;
        r = rem_reg;
        n = num_reg;
        for (int i = 0; i < CDIV_BITS; i++) begin
            trial = {r, n[NS_W-1]};
            n     = {n[NS_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor}) begin
                trial = trial - {1'b0, divisor};
                n[0]  = 1'b1;
            end
            r = trial[CDIV_W-1:0];
        end
        rem_next = r;
        num_next = n;
    end

    // Working registers.
    always_ff @(posedge aclk) begin
        if (load) begin
            rem_reg <= '0;
            num_reg <= dvd_in;
        end else if (step) begin
            rem_reg <= rem_next;
            num_reg <= num_next;
        end
    end

    assign quot = num_reg;

endmodule

>>> hdl/tntk_ctrl.sv
// Sequencer that steps one item at a time through the datapath.
module tntk_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  tntk_pkg::tntk_sts_t sts,
    output tntk_pkg::tntk_cmd_t cmd
);
    import tntk_pkg::*;

    tntk_state_t       state_reg;
    tntk_state_t       state_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              cal_last;
    logic              qdiv_last;

    assign cal_last  = (cnt_reg == CNT_W'(CAL_STEPS - 1));
    assign qdiv_last = (cnt_reg == CNT_W'(QDIV_STEPS - 1));

    // State and step counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // The counter runs only in the two iterating states.
    always_comb begin
        if ((state_reg == S_CAL_DIV) || (state_reg == S_QDIV)) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else begin
            cnt_next = '0;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                if (sts.kind_init) begin
                    state_next = sts.freq_zero ? S_FAULT : S_SEARCH;
                end else begin
                    state_next = sts.calibrated ? S_MUL : S_FAULT;
                end
            end
            S_FAULT:      state_next = S_QDIV;
            S_SEARCH: begin
                if (sts.search_hit) begin
                    state_next = S_CAL_DIV;
                end
            end
            S_CAL_DIV: begin
                if (cal_last) begin
                    state_next = S_CAL_COMMIT;
                end
            end
            S_CAL_COMMIT: state_next = S_MUL;
            S_MUL:        state_next = S_ADD;
            S_ADD:        state_next = S_QDIV;
            S_QDIV: begin
                if (qdiv_last) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (sts.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default:      state_next = S_IDLE;
        endcase
    end

    // Commands.
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                cmd.take = s_tvalid;
            end
            S_DECODE:     cmd.search_init = 1'b1;
            S_FAULT:      cmd.fault       = 1'b1;
            S_SEARCH: begin
                cmd.cal_load   = sts.search_hit;
                cmd.search_dec = !sts.search_hit;
            end
            S_CAL_DIV:    cmd.cal_step    = 1'b1;
            S_CAL_COMMIT: cmd.cal_commit  = 1'b1;
            S_MUL:        cmd.mul         = 1'b1;
            S_ADD:        cmd.add         = 1'b1;
            S_QDIV:       cmd.qdiv_step   = 1'b1;
            S_DONE:       cmd.out_load    = sts.out_free;
            default:      cmd             = '0;
        endcase
    end

endmodule

>>> hdl/tntk_dp.sv
// Datapath: calibration search and division, scaling, constant dividers and output register.
module tntk_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [tntk_pkg::TICK_W-1:0]         s_tdata,
    input  logic [tntk_pkg::KIND_W-1:0]         s_tuser,
    input  logic                                cfg_wr_en,
    input  logic [tntk_pkg::FREQ_W-1:0]         cfg_wr_data,
    input  logic                                m_tready,
    output logic                                m_tvalid,
    output logic [tntk_pkg::M_DATA_W-1:0]       m_tdata,
    output logic [tntk_pkg::STATUS_W-1:0]       m_tuser,
    input  tntk_pkg::tntk_cmd_t                 cmd,
    output tntk_pkg::tntk_sts_t                 sts
);
    import tntk_pkg::*;

    // Configuration and persistent state.
    logic [FREQ_W-1:0]   freq_reg;
    logic                calibrated_reg;
    logic [MULT_W-1:0]   mult_reg;
    logic [SHIFT_W-1:0]  shift_reg;
    logic [TICK_W-1:0]   last_ticks_reg;
    logic [NS_W-1:0]     last_time_reg;

    // Per-item working registers.
    logic [KIND_W-1:0]   kind_reg;
    logic [TICK_W-1:0]   ticks_reg;
    logic [SHIFT_W-1:0]  sh_reg;
    logic [FREQ_W-1:0]   cal_rem_reg;
    logic [FREQ_W-1:0]   cal_rem_next;
    logic [MULT_W-1:0]   cal_num_reg;
    logic [MULT_W-1:0]   cal_num_next;
    logic [NS_W-1:0]     prod_reg;
    logic [NS_W-1:0]     ns_reg;
    logic [STATUS_W-1:0] res_status_reg;

    // Output register.
    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;
    logic [STATUS_W-1:0] m_tuser_reg;

    logic [CAL_DVD_W-1:0] cal_dvd;
    logic [MULT_W-1:0]    delta;
    logic [NS_W-1:0]      prod_w;
    logic [NS_W-1:0]      sum_w;
    logic                 commit_time;
    logic [NS_W-1:0]      cdiv_in;
    logic                 cdiv_load;
    logic [NS_W-1:0]      quot_us;
    logic [NS_W-1:0]      quot_ms;

    // Trial dividend of the shift search: one second in ns, shifted.
    assign cal_dvd = CAL_DVD_W'(NS_PER_SEC) << sh_reg;

    // Calibration divider, one quotient bit per cycle.
    always_comb begin
        logic [FREQ_W:0] trial;
        trial = {cal_rem_reg, cal_num_reg[MULT_W-1]};
        if (trial >= {1'b0, freq_reg}) begin
            trial        = trial - {1'b0, freq_reg};
            cal_num_next = {cal_num_reg[MULT_W-2:0], 1'b1};
        end else begin
            cal_num_next = {cal_num_reg[MULT_W-2:0], 1'b0};
        end
        cal_rem_next = trial[FREQ_W-1:0];
    end

    // Scaling: only the low word of the tick delta counts.
    assign delta       = ticks_reg[MULT_W-1:0] - last_ticks_reg[MULT_W-1:0];
    assign prod_w      = mult_reg * delta;
    assign sum_w       = (prod_reg >> shift_reg) + last_time_reg;
    assign commit_time = (kind_reg == KIND_INIT) || (kind_reg == KIND_UPDATE);

    // Status towards the controller.
    assign sts.kind_init  = (kind_reg == KIND_INIT);
    assign sts.freq_zero  = (freq_reg == '0);
    assign sts.calibrated = calibrated_reg;
    assign sts.search_hit = (FREQ_W'(cal_dvd[CAL_DVD_W-1:MULT_W]) < freq_reg);
    assign sts.out_free   = !m_tvalid_reg || m_tready;

    // Control state, configuration and calibration results.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            freq_reg       <= FREQ_RESET;
            calibrated_reg <= 1'b0;
            mult_reg       <= '0;
            shift_reg      <= '0;
            last_ticks_reg <= '0;
            last_time_reg  <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                freq_reg <= cfg_wr_data;
            end
            if (cmd.cal_commit) begin
                calibrated_reg <= 1'b1;
                mult_reg       <= cal_num_reg;
                shift_reg      <= sh_reg;
                last_ticks_reg <= '0;
                last_time_reg  <= '0;
            end else if (cmd.add && commit_time) begin
                last_ticks_reg <= ticks_reg;
                last_time_reg  <= sum_w;
            end
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Working payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            kind_reg  <= s_tuser;
            ticks_reg <= s_tdata;
        end
        if (cmd.search_init) begin
            sh_reg <= MAX_SHIFT;
        end else if (cmd.search_dec) begin
            sh_reg <= sh_reg - SHIFT_W'(1);
        end
        if (cmd.cal_load) begin
            cal_rem_reg <= FREQ_W'(cal_dvd[CAL_DVD_W-1:MULT_W]);
            cal_num_reg <= cal_dvd[MULT_W-1:0];
        end else if (cmd.cal_step) begin
            cal_rem_reg <= cal_rem_next;
            cal_num_reg <= cal_num_next;
        end
        if (cmd.mul) begin
            prod_reg <= prod_w;
        end
        if (cmd.fault) begin
            ns_reg         <= '0;
            res_status_reg <= (kind_reg == KIND_INIT) ? STATUS_BAD_PARAM : STATUS_NOT_INIT;
        end else if (cmd.add) begin
            ns_reg         <= sum_w;
            res_status_reg <= STATUS_OK;
        end
        if (cmd.out_load) begin
            m_tdata_reg <= M_DATA_W'({quot_ms[MS_W-1:0], quot_us[US_W-1:0], ns_reg});
            m_tuser_reg <= res_status_reg;
        end
    end

    // Microsecond and millisecond dividers share the loaded timestamp.
    assign cdiv_load = cmd.add || cmd.fault;
    assign cdiv_in   = cmd.fault ? '0 : sum_w;

    tntk_cdiv u_div_us (
        .aclk    (aclk),
        .load    (cdiv_load),
        .dvd_in  (cdiv_in),
        .step    (cmd.qdiv_step),
        .divisor (DIV_US),
        .quot    (quot_us)
    );

    tntk_cdiv u_div_ms (
        .aclk    (aclk),
        .load    (cdiv_load),
        .dvd_in  (cdiv_in),
        .step    (cmd.qdiv_step),
        .divisor (DIV_MS),
        .quot    (quot_ms)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

>>> hdl/tntk_checker.sv
// Port-level checks for the timekeeper and their binding to the top level.
`include "assert_macros.svh"

module tntk_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [tntk_pkg::M_DATA_W-1:0]       m_tdata,
    input  logic [tntk_pkg::STATUS_W-1:0]       m_tuser
);
    import tntk_pkg::*;

    // A stalled result keeps its contents.
    `TNTK_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // A failed item reports a zero time in every field.
    `TNTK_ASSERT_IMP(a_fault_zero, aclk, aresetn, m_tvalid && (m_tuser != STATUS_OK), m_tdata == '0)

    // Only one item is in work at a time.
    `TNTK_ASSERT_NXT(a_one_item, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    // Reset empties the output register.
    `TNTK_ASSERT_RST(a_reset_out, aclk, aresetn, !m_tvalid)

endmodule

bind tick_to_nanosecond_timekeeper_top tntk_checker u_tntk_checker (.*);

>>> tb/sv/tick_to_nanosecond_timekeeper_top_test.sv
// Self-checking testbench for the tick-to-nanosecond timekeeper top level.
module tick_to_nanosecond_timekeeper_top_test;
    import tntk_pkg::*;

    // The spare kind code behaves as a read.
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_TAIL     = 20;
    localparam int REPORT_CAP     = 200;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 250;

    // One timestamp as the block reports it.
    typedef struct packed {
        logic [NS_W-1:0]     ns;
        logic [US_W-1:0]     us;
        logic [MS_W-1:0]     ms;
        logic [STATUS_W-1:0] status;
    } stamp_t;

    // Stimulus actions: send an item, write the frequency, or wait until idle.
    typedef enum logic [1:0] {
        ACT_ITEM,
        ACT_SETTING,
        ACT_DRAIN
    } plan_act_t;

    typedef struct {
        plan_act_t         act;
        logic [KIND_W-1:0] kind;
        logic [TICK_W-1:0] ticks;
        logic [FREQ_W-1:0] freq;
    } plan_entry_t;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [TICK_W-1:0]     s_tdata     = '0;
    logic [KIND_W-1:0]     s_tuser     = '0;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [STATUS_W-1:0]   m_tuser;
    logic                  cfg_wr_en   = 1'b0;
    logic [FREQ_W-1:0]     cfg_wr_data = '0;

    plan_entry_t stim_plan[$];
    stamp_t      awaited_stamps[$];

    // Timekeeper state as the testbench expects it.
    logic [FREQ_W-1:0] kp_freq       = FREQ_RESET;
    logic [MULT_W-1:0] kp_mult       = '0;
    logic [SHIFT_W-1:0] kp_shift     = '0;
    logic [TICK_W-1:0] kp_last_ticks = '0;
    logic [NS_W-1:0]   kp_last_time  = '0;
    logic              kp_calibrated = 1'b0;

    int fail_count    = 0;
    int feed_gap      = 0;
    int feed_calm     = 0;
    int sink_stall    = 0;
    int sink_calm     = 0;
    int idle_cycles   = 0;
    int n_init        = 0;
    int n_update      = 0;
    int n_read        = 0;
    int n_settings    = 0;
    int n_ok          = 0;
    int n_bad_param   = 0;
    int n_not_init    = 0;
    logic [TICK_W-1:0] tick_now;

    tick_to_nanosecond_timekeeper_top u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),     // tick_count
        .s_tuser     (s_tuser),     // kind
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),     // time_ns, time_us, time_ms
        .m_tuser     (m_tuser),     // status
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #5 aclk = ~aclk;

    // Scaled tick delta since the stored reference, added to the stored time.
    function automatic logic [NS_W-1:0] scaled_since_last(input logic [TICK_W-1:0] ticks);
        logic [TICK_W-1:0] diff;
        logic [63:0]       prod;
        diff = ticks - kp_last_ticks;
        prod = {32'd0, kp_mult} * {32'd0, diff[31:0]};
        return (prod >> kp_shift) + kp_last_time;
    endfunction

    // Works out the timestamp for one item and advances the expected state.
    function automatic stamp_t compute_stamp(input logic [KIND_W-1:0] kind,
                                             input logic [TICK_W-1:0] ticks);
        stamp_t            res;
        logic [NS_W-1:0]   ns;
        logic [63:0]       quo;
        logic [SHIFT_W-1:0] sh;
        logic [STATUS_W-1:0] st;
        ns = '0;
        st = STATUS_OK;
        if (kind == KIND_INIT) begin
            if (kp_freq == '0) begin
                st = STATUS_BAD_PARAM;
            end else begin
                // Largest shift at which the multiplier still fits in 32 bits.
                sh  = MAX_SHIFT;
                quo = (64'(NS_PER_SEC) << sh) / {24'd0, kp_freq};
                while (quo > 64'hFFFF_FFFF && sh != '0) begin
                    sh  = sh - 1'b1;
                    quo = (64'(NS_PER_SEC) << sh) / {24'd0, kp_freq};
                end
                kp_mult       = quo[31:0];
                kp_shift      = sh;
                kp_last_ticks = '0;
                kp_last_time  = '0;
                kp_calibrated = 1'b1;
                ns            = scaled_since_last(ticks);
                kp_last_time  = ns;
                kp_last_ticks = ticks;
            end
        end else if (!kp_calibrated) begin
            st = STATUS_NOT_INIT;
        end else if (kind == KIND_UPDATE) begin
            ns            = scaled_since_last(ticks);
            kp_last_time  = ns;
            kp_last_ticks = ticks;
        end else begin
            ns = scaled_since_last(ticks);
        end
        res.ns     = ns;
        res.us     = US_W'(ns / 64'd1000);
        res.ms     = MS_W'(ns / 64'd1000000);
        res.status = st;
        return res;
    endfunction

    // Pause length: mostly none or short, now and then a long one.
    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Frequency settings spread over the whole register range.
    function automatic logic [FREQ_W-1:0] pick_frequency();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return FREQ_W'($urandom_range(1, 10));
        if (r < 30) return {FREQ_W{1'b1}} - FREQ_W'($urandom_range(0, 1000));
        if (r < 45) return FREQ_W'(1000000000) + FREQ_W'($urandom_range(0, 2000)) - 40'd1000;
        if (r < 55) return '0;
        if (r < 70) return FREQ_W'($urandom_range(32000, 33000));
        return {8'($urandom_range(0, 255)), 32'($urandom)};
    endfunction

    task automatic add_item(input logic [KIND_W-1:0] kind, input logic [TICK_W-1:0] ticks);
        plan_entry_t e;
        e.act   = ACT_ITEM;
        e.kind  = kind;
        e.ticks = ticks;
        e.freq  = '0;
        stim_plan.push_back(e);
    endtask

    task automatic add_setting(input logic [FREQ_W-1:0] freq);
        plan_entry_t e;
        e.act   = ACT_SETTING;
        e.kind  = '0;
        e.ticks = '0;
        e.freq  = freq;
        stim_plan.push_back(e);
    endtask

    task automatic add_drain();
        plan_entry_t e;
        e.act   = ACT_DRAIN;
        e.kind  = '0;
        e.ticks = '0;
        e.freq  = '0;
        stim_plan.push_back(e);
    endtask

    task automatic check_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            fail_count++;
            if (fail_count <= REPORT_CAP)
                $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
        end
    endtask

    // Sender: presents planned items, and writes the frequency only when idle.
    always @(posedge aclk) begin : feed_proc
        logic        valid_next;
        logic        cfg_next;
        plan_entry_t head;
        valid_next = s_tvalid;
        cfg_next   = 1'b0;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                valid_next = 1'b0;
                if (feed_calm > 0) begin
                    feed_calm--;
                    feed_gap = 0;
                end else if ($urandom_range(0, 99) < 4) begin
                    feed_calm = $urandom_range(30, 150);
                    feed_gap  = 0;
                end else begin
                    feed_gap = pick_pause();
                end
            end
            if (!valid_next && feed_gap > 0) begin
                feed_gap--;
            end else if (!valid_next && stim_plan.size() > 0) begin
                head = stim_plan[0];
                case (head.act)
                    ACT_ITEM: begin
                        s_tdata    <= head.ticks;
                        s_tuser    <= head.kind;
                        valid_next = 1'b1;
                        stim_plan.delete(0);
                    end
                    ACT_SETTING: begin
                        if (!s_tvalid && awaited_stamps.size() == 0) begin
                            cfg_next = 1'b1;
                            cfg_wr_data <= head.freq;
                            stim_plan.delete(0);
                        end
                    end
                    default: begin
                        if (!s_tvalid && awaited_stamps.size() == 0)
                            stim_plan.delete(0);
                    end
                endcase
            end
        end
        s_tvalid  <= valid_next;
        cfg_wr_en <= cfg_next;
    end

    // Receiver: random stalls, with long stretches of steady readiness.
    always @(posedge aclk) begin : sink_proc
        logic ready_next;
        ready_next = 1'b1;
        if (sink_stall > 0) begin
            sink_stall--;
            ready_next = 1'b0;
        end else if (sink_calm > 0) begin
            sink_calm--;
        end else if ($urandom_range(0, 99) < 5) begin
            sink_calm = $urandom_range(50, 300);
        end else begin
            sink_stall = pick_pause();
            sink_calm  = $urandom_range(0, 4);
        end
        m_tready <= ready_next;
    end

    // Monitor: checks each result transfer, then records new settings and items.
    always @(posedge aclk) begin : watch_proc
        stamp_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (awaited_stamps.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_CAP)
                        $display("%0t: unexpected result: expected none, actual ns %h status %0d",
                                 $time, m_tdata[NS_LSB +: NS_W], m_tuser);
                end else begin
                    want = awaited_stamps.pop_front();
                    check_field("time_ns", want.ns, m_tdata[NS_LSB +: NS_W]);
                    check_field("time_us", 64'(want.us), 64'(m_tdata[US_LSB +: US_W]));
                    check_field("time_ms", 64'(want.ms), 64'(m_tdata[MS_LSB +: MS_W]));
                    check_field("status", 64'(want.status), 64'(m_tuser));
                    case (want.status)
                        STATUS_OK:        n_ok++;
                        STATUS_BAD_PARAM: n_bad_param++;
                        default:          n_not_init++;
                    endcase
                end
            end
            if (cfg_wr_en) begin
                kp_freq = cfg_wr_data;
                n_settings++;
            end
            if (s_tvalid && s_tready) begin
                case (s_tuser)
                    KIND_INIT:   n_init++;
                    KIND_UPDATE: n_update++;
                    default:     n_read++;
                endcase
                awaited_stamps.push_back(compute_stamp(s_tuser, s_tdata));
            end
        end
    end

    // Watchdog on cycles in which nothing moves.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                     $time, WATCHDOG_LIMIT, awaited_stamps.size());
            $display("tick_to_nanosecond_timekeeper_top verification failed");
            $finish;
        end
    end

    // Stimulus plan, reset and end of run.
    initial begin
        // Updates and reads before any init, including the spare kind.
        add_item(KIND_READ, 64'd0);
        add_item(KIND_UPDATE, {TICK_W{1'b1}});
        add_item(KIND_SPARE, 64'h5555_5555_5555_5555);
        // Calibration at the reset frequency of 1 GHz.
        add_item(KIND_INIT, 64'd12345);
        add_item(KIND_UPDATE, 64'd1012345);
        add_item(KIND_READ, 64'd2000000);
        add_item(KIND_SPARE, 64'hAAAA_AAAA_0001_0000);
        // Zero frequency is refused and the earlier calibration survives.
        add_setting('0);
        add_item(KIND_INIT, 64'd777);
        add_item(KIND_READ, 64'd1017345);
        // Lowest frequency: the stored time wraps after a few full-range deltas.
        add_setting(40'd1);
        add_item(KIND_INIT, {TICK_W{1'b1}});
        add_item(KIND_UPDATE, 64'h0000_0000_FFFF_FFFE);
        add_item(KIND_UPDATE, 64'h0000_0001_FFFF_FFFD);
        add_item(KIND_UPDATE, 64'h0000_0002_FFFF_FFFC);
        add_item(KIND_UPDATE, 64'h0000_0003_FFFF_FFFB);
        add_item(KIND_UPDATE, 64'h0000_0004_FFFF_FFFA);
        // Highest frequency, zero delta and deltas beyond 32 bits.
        add_setting({FREQ_W{1'b1}});
        add_item(KIND_INIT, 64'd0);
        add_item(KIND_UPDATE, 64'h0000_0000_FFFF_FFFF);
        add_item(KIND_UPDATE, 64'h0000_0000_FFFF_FFFF);
        add_item(KIND_READ, 64'h1234_5678_0000_0010);
        // A new frequency is not used until the next init.
        add_setting(40'd1000000);
        add_item(KIND_READ, 64'h0000_0001_0000_0000);
        add_item(KIND_INIT, 64'd99);
        add_item(KIND_UPDATE, 64'd100099);

        // Random phases: a new setting, an init, then a mostly rising counter.
        tick_now = rand64();
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            add_setting(pick_frequency());
            add_item(KIND_INIT, tick_now);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                int r;
                int step;
                r    = $urandom_range(0, 99);
                step = $urandom_range(0, 99);
                if (step < 55)
                    tick_now = tick_now + 64'($urandom_range(0, 5000));
                else if (step < 80)
                    tick_now = tick_now + 64'($urandom);
                else if (step < 92)
                    tick_now = rand64();
                else if (step < 96)
                    tick_now = tick_now + 64'hFFFF_FFFF;
                if (r < 3)
                    add_item(KIND_INIT, tick_now);
                else if (r < 7)
                    add_item(KIND_SPARE, tick_now);
                else if (r < 52)
                    add_item(KIND_UPDATE, tick_now);
                else
                    add_item(KIND_READ, tick_now);
                if ($urandom_range(0, 199) == 0)
                    add_drain();
            end
            add_drain();
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        while (stim_plan.size() != 0 || s_tvalid || awaited_stamps.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_TAIL) @(posedge aclk);

        $display("Items: %0d init, %0d update, %0d read or spare, over %0d frequency writes.",
                 n_init, n_update, n_read, n_settings);
        $display("Results: %0d ok, %0d bad parameter, %0d not initialised.",
                 n_ok, n_bad_param, n_not_init);
        if (fail_count == 0) begin
            $display("tick_to_nanosecond_timekeeper_top verification clean");
        end else begin
            $display("tick_to_nanosecond_timekeeper_top verification failed");
        end
        $finish;
    end

endmodule
